FILE: src/block_scaled_int8_dot_accumulator_macros.svh
// Assertion macros for the block-scaled dot accumulator.
// Each expects clk and rst in scope.
`ifndef BLOCK_SCALED_INT8_DOT_ACCUMULATOR_MACROS_SVH
`define BLOCK_SCALED_INT8_DOT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication.
`define BSDA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BSDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/bsda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_pkg
// Shared types, constants and fp32 helper functions for the dot accumulator.
// ----------------------------------------------------------------------------
package bsda_pkg;

  localparam int QSUM_W = 24;  // holds the largest block sum for block lengths up to 511
  localparam int RAW_W  = 50;  // working significand of the float unit
  localparam int EXP_W  = 13;  // signed working exponent

  localparam logic WFMT_Q8 = 1'b0;
  localparam logic WFMT_Q4 = 1'b1;

  localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [7:0]  F32_EMAX = 8'hFF;

  // Fold request: one finished block sum and what to do with it
  typedef struct packed {
    logic signed [QSUM_W-1:0] sum;
    logic [31:0]              act_scale;
    logic [15:0]              wscale_half;
    logic                     load;
    logic [31:0]              init;
    logic                     emit;
  } fold_req_t;

  // Unpacked float operand; exponent is biased, subnormals use exponent 1
  typedef struct packed {
    logic        sign;
    logic [9:0]  ex;
    logic [23:0] man;
    logic        nan;
    logic        inf;
  } fop_t;

  function automatic fop_t unpack32(input logic [31:0] b);
    fop_t u;
    u.sign = b[31];
    u.ex   = (b[30:23] == 8'd0) ? 10'd1 : {2'b0, b[30:23]};
    u.man  = {b[30:23] != 8'd0, b[22:0]};
    u.nan  = (b[30:23] == F32_EMAX) && (b[22:0] != 23'd0);
    u.inf  = (b[30:23] == F32_EMAX) && (b[22:0] == 23'd0);
    return u;
  endfunction

  // Half widened to single; subnormal halves stay unnormalized
  function automatic fop_t unpack16(input logic [15:0] h);
    fop_t u;
    u.sign = h[15];
    u.ex   = ((h[14:10] == 5'd0) ? 10'd1 : {5'b0, h[14:10]}) + 10'd112;
    u.man  = {h[14:10] != 5'd0, h[9:0], 13'b0};
    u.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    u.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
    return u;
  endfunction

  function automatic logic [5:0] lzc50(input logic [RAW_W-1:0] v);
    logic [5:0] n;
    logic       hit;
    n   = '0;
    hit = 1'b0;
    for (int i = RAW_W - 1; i >= 0; i--) begin
      if (!hit) begin
        if (v[i]) hit = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // Round to nearest even; r normalized with leading one at bit RAW_W-1,
  // value = r / 2^(RAW_W-1) * 2^(ex-127)
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [EXP_W-1:0] ex,
                                             input logic [RAW_W-1:0] r);
    logic [RAW_W-1:0] s;
    logic [23:0]      m;
    logic             g;
    logic             st;
    logic             rup;
    logic [7:0]       ef;
    logic [6:0]       sh;
    logic [30:0]      mag;
    s  = r;
    ef = '0;
    sh = '0;
    if (r == '0) return {sign, 31'b0};
    if (ex >= 13'sd255) return {sign, F32_EMAX, 23'b0};
    if (ex >= 13'sd1) begin
      ef = ex[7:0] - 8'd1;
    end else if (ex < -13'sd48) begin
      s = {{(RAW_W-1){1'b0}}, 1'b1};
    end else begin
      sh = 7'(13'sd1 - ex);
      s  = (r >> sh) | {{(RAW_W-1){1'b0}}, |(r << (7'(RAW_W) - sh))};
    end
    m   = s[RAW_W-1:RAW_W-24];
    g   = s[RAW_W-25];
    st  = |s[RAW_W-26:0];
    rup = g & (st | m[0]);
    mag = {ef, 23'b0} + {7'b0, m} + {30'b0, rup};
    return {sign, mag};
  endfunction

endpackage

FILE: src/bsda_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_in_if
// Input element channel: activation, weight code, scales and framing flags.
// ----------------------------------------------------------------------------
interface bsda_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] act_value;
  logic [7:0]        weight_code;
  logic [31:0]       act_scale;
  logic [15:0]       weight_scale_half;
  logic              start_dot;
  logic              use_initial;
  logic [31:0]       initial_value;
  logic              end_dot;

  modport source(output valid, act_value, weight_code, act_scale, weight_scale_half,
                 start_dot, use_initial, initial_value, end_dot, input ready);
  modport sink(input valid, act_value, weight_code, act_scale, weight_scale_half,
               start_dot, use_initial, initial_value, end_dot, output ready);
endinterface

FILE: src/bsda_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_out_if
// Result channel: fp32 bits of a finished dot product.
// ----------------------------------------------------------------------------
interface bsda_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_result;

  modport source(output valid, dot_result, input ready);
  modport sink(input valid, dot_result, output ready);
endinterface

FILE: src/block_scaled_int8_dot_accumulator.sv
`timescale 1ns / 1ps
// Throughput: one element per cycle; each block fold runs through the
// shared float back end (convert, two multiplies, add; each setup, normalize, round).
// Folds wait in the two-entry queue while the back end is busy; with it full the input
// stalls, and an ending fold waits while the previous result is not yet taken.
// Reset (rst, synchronous) clears sums, counters, queue, accumulator (+0.0) and format.
// ----------------------------------------------------------------------------
// block_scaled_int8_dot_accumulator
// Block-quantized int8 dot product with fp32 accumulation of scaled block sums.
// ----------------------------------------------------------------------------
`include "block_scaled_int8_dot_accumulator_macros.svh"

module block_scaled_int8_dot_accumulator #(
  parameter int BLOCK_LEN = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_data,
  bsda_in_if.sink    in_ch,
  bsda_out_if.source out_ch
);
  import bsda_pkg::*;

  logic      weight_format;
  logic      q_push;
  logic      q_pop;
  logic      q_valid;
  logic      q_full;
  fold_req_t q_in;
  fold_req_t q_head;

  // Hold the weight format register
  always_ff @(posedge clk) begin
    if (rst) weight_format <= WFMT_Q8;
    else if (cfg_we) weight_format <= cfg_data;
  end

  bsda_front #(.BLOCK_LEN(BLOCK_LEN)) u_front (
    .clk(clk), .rst(rst), .weight_format(weight_format), .in_ch(in_ch),
    .q_full(q_full), .push(q_push), .entry(q_in)
  );

  bsda_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .pop(q_pop),
    .q_valid(q_valid), .q_full(q_full), .dout(q_head)
  );

  bsda_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .pop(q_pop),
    .out_ch(out_ch)
  );

  `BSDA_ASSERT_IMPL(a_no_overflow, q_push, !q_full, "fold request pushed into a full queue")
  `BSDA_ASSERT_IMPL(a_emit_slot, q_pop && q_head.emit, !out_ch.valid, "result slot busy")
  `BSDA_ASSERT_NEXT(a_push_lands, q_push, q_valid, "pushed request not visible")

endmodule

FILE: src/bsda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_front
// Decodes weights, keeps the integer block sum and issues fold requests.
// ----------------------------------------------------------------------------
module bsda_front #(
  parameter int BLOCK_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 weight_format,
  bsda_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 push,
  output bsda_pkg::fold_req_t  entry
);
  import bsda_pkg::*;

  localparam int SUM_W = $clog2(BLOCK_LEN) + 16;
  localparam int IDX_W = $clog2(BLOCK_LEN);

  logic signed [SUM_W-1:0] sum;
  logic [IDX_W-1:0]        idx;
  logic                    pend_load;
  logic [31:0]             pend_init;

  logic signed [SUM_W-1:0] base_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic [IDX_W-1:0]        base_idx;
  logic signed [7:0]       w;
  logic signed [15:0]      prod;
  logic                    fold;
  logic                    accept;
  logic                    ld;
  logic [31:0]             ld_val;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Decode weight, multiply, add into the block sum
  always_comb begin
    if (weight_format == WFMT_Q4) w = $signed({4'b0, in_ch.weight_code[3:0]}) - 8'sd8;
    else w = $signed(in_ch.weight_code);
    prod     = in_ch.act_value * w;
    base_sum = in_ch.start_dot ? '0 : sum;
    base_idx = in_ch.start_dot ? '0 : idx;
    sum_next = base_sum + SUM_W'(prod);
    fold     = (base_idx == IDX_W'(BLOCK_LEN - 1)) || in_ch.end_dot;
    ld       = in_ch.start_dot || pend_load;
    ld_val   = in_ch.start_dot ? (in_ch.use_initial ? in_ch.initial_value : 32'd0)
                               : pend_init;
  end

  // Build the fold request
  always_comb begin
    push              = accept && fold;
    entry.sum         = QSUM_W'(sum_next);
    entry.act_scale   = in_ch.act_scale;
    entry.wscale_half = in_ch.weight_scale_half;
    entry.load        = ld;
    entry.init        = ld_val;
    entry.emit        = in_ch.end_dot;
  end

  // Advance the block state
  always_ff @(posedge clk) begin
    if (rst) begin
      sum       <= '0;
      idx       <= '0;
      pend_load <= 1'b0;
    end else if (accept) begin
      if (fold) begin
        sum       <= '0;
        idx       <= '0;
        pend_load <= 1'b0;
      end else begin
        sum       <= sum_next;
        idx       <= base_idx + IDX_W'(1);
        pend_load <= ld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !fold) pend_init <= ld_val;
  end

endmodule

FILE: src/bsda_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_queue
// Two-entry queue of fold requests between the front and the float back end.
// ----------------------------------------------------------------------------
module bsda_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bsda_pkg::fold_req_t din,
  input  logic                pop,
  output logic                q_valid,
  output logic                q_full,
  output bsda_pkg::fold_req_t dout
);
  import bsda_pkg::*;

  fold_req_t  mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign q_valid = (cnt != 2'd0);
  assign q_full  = (cnt == 2'd2);
  assign dout    = mem[rp];

  // Store a request
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: src/bsda_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsda_back
// Float back end: converts the block sum, scales it twice, adds it into the
// fp32 accumulator and presents the result when the dot product ends.
// ----------------------------------------------------------------------------
module bsda_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  bsda_pkg::fold_req_t q_head,
  output logic                pop,
  bsda_out_if.source          out_ch
);
  import bsda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OP   = 4'b0010,
    S_NORM = 4'b0100,
    S_RND  = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    OP_CONV = 2'd0,
    OP_MUL1 = 2'd1,
    OP_MUL2 = 2'd2,
    OP_ADD  = 2'd3
  } op_t;

  state_t                  state;
  op_t                     op;
  fold_req_t               req;
  logic [31:0]             x;
  logic [31:0]             acc;
  logic [RAW_W-1:0]        raw;
  logic signed [EXP_W-1:0] rex;
  logic                    rsign;
  logic                    spec;
  logic [31:0]             spec_bits;
  logic                    out_valid;
  logic [31:0]             out_data;

  fop_t                    ua;
  fop_t                    ub;
  fop_t                    bg;
  fop_t                    sm;
  logic [QSUM_W-1:0]       smag;
  logic [9:0]              d;
  logic [RAW_W-1:0]        bigr;
  logic [RAW_W-1:0]        smr0;
  logic [RAW_W-1:0]        smr;
  logic [RAW_W-1:0]        o_raw;
  logic signed [EXP_W-1:0] o_ex;
  logic                    o_sign;
  logic                    o_spec;
  logic [31:0]             o_spec_bits;
  logic [5:0]              lz;
  logic [31:0]             res;

  assign out_ch.valid      = out_valid;
  assign out_ch.dot_result = out_data;
  assign pop = q_valid && (state == S_IDLE) && (!out_valid || !q_head.emit);

  // Operand setup for the current step
  always_comb begin
    ua          = unpack32((op == OP_ADD) ? acc : x);
    ub          = unpack32(x);
    bg          = ua;
    sm          = ub;
    smag        = '0;
    d           = '0;
    bigr        = '0;
    smr0        = '0;
    smr         = '0;
    o_raw       = '0;
    o_ex        = '0;
    o_sign      = 1'b0;
    o_spec      = 1'b0;
    o_spec_bits = F32_QNAN;
    unique case (op)
      OP_CONV: begin
        smag   = req.sum[QSUM_W-1] ? (QSUM_W'(0) - req.sum) : req.sum;
        o_raw  = RAW_W'(smag);
        o_ex   = 13'sd176;
        o_sign = req.sum[QSUM_W-1];
      end
      OP_MUL1, OP_MUL2: begin
        ub     = (op == OP_MUL1) ? unpack16(req.wscale_half) : unpack32(req.act_scale);
        o_sign = ua.sign ^ ub.sign;
        o_raw  = RAW_W'(ua.man * ub.man);
        o_ex   = EXP_W'({3'b0, ua.ex}) + EXP_W'({3'b0, ub.ex}) - 13'sd124;
        if (ua.nan || ub.nan || (ua.inf && ub.man == 24'd0) || (ub.inf && ua.man == 24'd0))
        begin
          o_spec      = 1'b1;
          o_spec_bits = F32_QNAN;
        end else if (ua.inf || ub.inf) begin
          o_spec      = 1'b1;
          o_spec_bits = {o_sign, F32_EMAX, 23'b0};
        end
      end
      OP_ADD: begin
        if ({ua.ex, ua.man} >= {ub.ex, ub.man}) begin
          bg = ua;
          sm = ub;
        end else begin
          bg = ub;
          sm = ua;
        end
        d    = bg.ex - sm.ex;
        bigr = {2'b0, bg.man, 24'b0};
        smr0 = {2'b0, sm.man, 24'b0};
        if (d >= 10'(RAW_W)) smr = {{(RAW_W-1){1'b0}}, |sm.man};
        else smr = (smr0 >> d) | {{(RAW_W-1){1'b0}}, |(smr0 << (10'(RAW_W) - d))};
        o_raw  = (bg.sign == sm.sign) ? (bigr + smr) : (bigr - smr);
        o_sign = (o_raw == '0 && bg.sign != sm.sign) ? 1'b0 : bg.sign;
        o_ex   = EXP_W'({3'b0, bg.ex}) + 13'sd2;
        if (ua.nan || ub.nan || (ua.inf && ub.inf && ua.sign != ub.sign)) begin
          o_spec      = 1'b1;
          o_spec_bits = F32_QNAN;
        end else if (ua.inf || ub.inf) begin
          o_spec      = 1'b1;
          o_spec_bits = {ua.inf ? ua.sign : ub.sign, F32_EMAX, 23'b0};
        end
      end
      default: ;
    endcase
  end

  assign lz  = lzc50(raw);
  assign res = spec ? spec_bits : round_pack(rsign, rex, raw);

  // Sequence the four float steps of a fold
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_CONV;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (q_head.load) acc <= q_head.init;
            op    <= OP_CONV;
            state <= S_OP;
          end
        end
        S_OP: state <= S_NORM;
        S_NORM: state <= S_RND;
        S_RND: begin
          if (op == OP_ADD) begin
            acc <= res;
            if (req.emit) out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            op    <= op_t'(op + 2'd1);
            state <= S_OP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop) req <= q_head;
    if (state == S_OP) begin
      raw       <= o_raw;
      rex       <= o_ex;
      rsign     <= o_sign;
      spec      <= o_spec;
      spec_bits <= o_spec_bits;
    end
    if (state == S_NORM) begin
      raw <= raw << lz;
      rex <= rex - EXP_W'(lz);
    end
    if (state == S_RND) begin
      x <= res;
      if (op == OP_ADD && req.emit) out_data <= res;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block-scaled int8 dot accumulator. A directed
// table covers field extremes, both weight formats and the float corner
// cases, then random dot products of mixed lengths run under random idling
// on both channels. Results are checked against a bit-exact fp32 predictor.
// ----------------------------------------------------------------------------
module tb;
  import bsda_pkg::*;

  localparam int BLK = 32;
  localparam int SETTLE = 80;

  typedef struct packed {
    logic signed [7:0] act;
    logic [7:0]        code;
    logic [31:0]       ascale;
    logic [15:0]       wscale;
    logic              first;
    logic              use_init;
    logic [31:0]       init;
    logic              last;
  } elem_t;

  typedef struct packed {
    logic        fmt;
    elem_t       el;
    logic        typed;
    logic [31:0] result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;

  bsda_in_if  in_ch();
  bsda_out_if out_ch();

  block_scaled_int8_dot_accumulator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  int          blk_sum;
  int          blk_cnt;
  logic [31:0] acc_bits;
  logic        fmt_cur;

  logic [31:0] dot_expect_q[$];
  int          err_cnt = 0;
  bit          quiet = 1'b0;
  dir_row_t    dir_tab[21];
  int          sent;

  // Round a magnitude m * 2^e to fp32, nearest even
  function automatic logic [31:0] fp32_round(logic sign, int e, logic [127:0] m);
    int           p;
    int           ex;
    int           sh;
    logic [127:0] keep;
    logic         g;
    logic         st;
    logic         rup;
    logic [31:0]  pk;
    if (m == '0) return {sign, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    ex = p + e + 127;
    if (ex >= 255) return {sign, 8'hFF, 23'b0};
    sh = (ex >= 1) ? p - 23 : p - 23 + 1 - ex;
    if (sh >= 128) return {sign, 31'b0};
    if (sh <= 0) begin
      keep = m << (-sh);
      g = 1'b0;
      st = 1'b0;
    end else begin
      keep = m >> sh;
      g = m[sh-1];
      st = |(m & ((128'd1 << (sh - 1)) - 128'd1));
    end
    rup = g & (st | keep[0]);
    pk = ((ex >= 1) ? (32'(ex - 1) << 23) : 32'd0) + keep[31:0] + 32'(rup);
    if (pk >= 32'h7F80_0000) return {sign, 8'hFF, 23'b0};
    return {sign, pk[30:0]};
  endfunction

  function automatic int lsb_exp(logic [31:0] b);
    return ((b[30:23] == 8'd0) ? 1 : int'(b[30:23])) - 150;
  endfunction

  function automatic logic [23:0] sig24(logic [31:0] b);
    return {b[30:23] != 8'd0, b[22:0]};
  endfunction

  function automatic bit is_nan(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] fp32_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return F32_QNAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == '0 || b[30:0] == '0) return F32_QNAN;
      return {s, 8'hFF, 23'b0};
    end
    if (a[30:0] == '0 || b[30:0] == '0) return {s, 31'b0};
    return fp32_round(s, lsb_exp(a) + lsb_exp(b), 128'(sig24(a)) * 128'(sig24(b)));
  endfunction

  function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
    logic [31:0]  hi;
    logic [31:0]  lo;
    logic [127:0] mh;
    logic [127:0] ml;
    int           d;
    if (is_nan(a) || is_nan(b)) return F32_QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? F32_QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
    if (a[30:0] == '0) return b;
    if (b[30:0] == '0) return a;
    // align the operand with the larger exponent onto the smaller one
    if (lsb_exp(a) >= lsb_exp(b)) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    d = lsb_exp(hi) - lsb_exp(lo);
    if (d > 60) return hi;
    mh = 128'(sig24(hi)) << d;
    ml = 128'(sig24(lo));
    if (hi[31] == lo[31]) return fp32_round(hi[31], lsb_exp(lo), mh + ml);
    if (mh == ml) return 32'h0000_0000;
    if (mh > ml) return fp32_round(hi[31], lsb_exp(lo), mh - ml);
    return fp32_round(lo[31], lsb_exp(lo), ml - mh);
  endfunction

  function automatic logic [31:0] half_widen(logic [15:0] h);
    logic [31:0] sign;
    logic [31:0] ex;
    logic [31:0] man;
    sign = {h[15], 31'b0};
    ex = 32'(h[14:10]);
    man = 32'(h[9:0]);
    if (ex == 32'h1F) return sign | 32'h7F80_0000 | (man << 13);
    if (ex != 0) return sign | ((ex + 32'd112) << 23) | (man << 13);
    if (man == 0) return sign;
    ex = 32'd113;
    while (man[10] == 1'b0) begin
      man = man << 1;
      ex = ex - 1;
    end
    return sign | (ex << 23) | ((man & 32'h3FF) << 13);
  endfunction

  // Advance the predictor by one element; returns 1 with the result on an end
  function automatic bit model_element(elem_t el, output logic [31:0] res);
    int          w;
    logic [31:0] t;
    if (el.first) begin
      blk_sum = 0;
      blk_cnt = 0;
      acc_bits = el.use_init ? el.init : 32'h0;
    end
    if (fmt_cur == WFMT_Q4) w = int'(el.code[3:0]) - 8;
    else w = int'($signed(el.code));
    blk_sum += int'(el.act) * w;
    blk_cnt++;
    if (blk_cnt >= BLK || el.last) begin
      t = fp32_round(blk_sum < 0, 0, 128'((blk_sum < 0) ? -blk_sum : blk_sum));
      t = fp32_mul(t, half_widen(el.wscale));
      t = fp32_mul(t, el.ascale);
      acc_bits = fp32_add(acc_bits, t);
      blk_sum = 0;
      blk_cnt = 0;
    end
    res = acc_bits;
    return el.last;
  endfunction

  function automatic dir_row_t row(logic fmt, int act, int code, logic [31:0] as,
                                   logic [15:0] ws, bit st, bit ui, logic [31:0] init,
                                   bit en, bit typed, logic [31:0] result);
    dir_row_t r;
    r.fmt = fmt;
    r.el.act = 8'(act);
    r.el.code = 8'(code);
    r.el.ascale = as;
    r.el.wscale = ws;
    r.el.first = st;
    r.el.use_init = ui;
    r.el.init = init;
    r.el.last = en;
    r.typed = typed;
    r.result = result;
    return r;
  endfunction

  // Send one request; returns at the edge where it is accepted
  task automatic send_elem(elem_t el, bit typed, logic [31:0] typed_res);
    logic [31:0] res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.act_value <= el.act;
    in_ch.weight_code <= el.code;
    in_ch.act_scale <= el.ascale;
    in_ch.weight_scale_half <= el.wscale;
    in_ch.start_dot <= el.first;
    in_ch.use_initial <= el.use_init;
    in_ch.initial_value <= el.init;
    in_ch.end_dot <= el.last;
    do @(posedge clk); while (!in_ch.ready);
    if (model_element(el, res)) dot_expect_q.push_back(typed ? typed_res : res);
    sent++;
  endtask

  // Drop valid and hold until the block has drained
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (dot_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_format(logic v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    fmt_cur = v;
  endtask

  function automatic logic [31:0] rand_f32();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(100, 150)), 23'($urandom)};
  endfunction

  function automatic logic [15:0] rand_f16();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(5, 25)), 10'($urandom)};
  endfunction

  // Random dot product, mostly well framed, sometimes broken
  task automatic send_random_dot();
    int    len;
    bit    no_start;
    elem_t el;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(BLK + 1, 100) : $urandom_range(1, BLK);
    no_start = ($urandom_range(0, 9) == 0);
    for (int j = 0; j < len; j++) begin
      el.act = 8'($urandom);
      el.code = 8'($urandom);
      el.ascale = rand_f32();
      el.wscale = rand_f16();
      el.first = (j == 0) && !no_start;
      el.use_init = 1'($urandom);
      el.init = rand_f32();
      el.last = (j == len - 1);
      if ($urandom_range(0, 19) == 0) el.first = 1'($urandom);
      if ($urandom_range(0, 19) == 0) el.last = 1'($urandom);
      send_elem(el, 1'b0, 32'h0);
    end
  endtask

  // Randomly stall the result channel
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (dot_expect_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time,
                 out_ch.dot_result);
        err_cnt++;
      end else begin
        if (out_ch.dot_result !== dot_expect_q[0]) begin
          $display("%0t: dot_result mismatch: expected %h, actual %h", $time,
                   dot_expect_q[0], out_ch.dot_result);
          err_cnt++;
        end
        void'(dot_expect_q.pop_front());
      end
    end
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.act_value = '0;
    in_ch.weight_code = '0;
    in_ch.act_scale = '0;
    in_ch.weight_scale_half = '0;
    in_ch.start_dot = 1'b0;
    in_ch.use_initial = 1'b0;
    in_ch.initial_value = '0;
    in_ch.end_dot = 1'b0;
    blk_sum = 0;
    blk_cnt = 0;
    acc_bits = 32'h0;
    fmt_cur = WFMT_Q8;
    sent = 0;

    dir_tab[0]  = row(WFMT_Q8, 0, 8'h00, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'h0000_0000);
    dir_tab[1]  = row(WFMT_Q8, 1, 8'h01, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'h3F80_0000);
    dir_tab[2]  = row(WFMT_Q8, -128, 8'h80, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1,
                      32'h4680_0000);
    dir_tab[3]  = row(WFMT_Q8, 127, 8'h7F, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 0, 0);
    dir_tab[4]  = row(WFMT_Q8, 0, 8'h00, 32'h7FC0_0001, 16'h3C00, 1, 0, 0, 1, 1, F32_QNAN);
    dir_tab[5]  = row(WFMT_Q8, 0, 8'h00, 32'h3F80_0000, 16'h3C00, 1, 1, 32'h4000_0000, 1, 1,
                      32'h4000_0000);
    // partial block continued from a negative infinity start value
    dir_tab[6]  = row(WFMT_Q8, 5, 8'h03, 32'h3F80_0000, 16'h3C00, 1, 1, 32'hFF80_0000, 0, 0, 0);
    dir_tab[7]  = row(WFMT_Q8, -3, 8'hFD, 32'h3F80_0000, 16'h3C00, 0, 0, 0, 1, 0, 0);
    dir_tab[8]  = row(WFMT_Q8, 1, 8'h01, 32'h7F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'h7F80_0000);
    dir_tab[9]  = row(WFMT_Q8, 0, 8'h00, 32'h7F80_0000, 16'h3C00, 1, 0, 0, 1, 1, F32_QNAN);
    dir_tab[10] = row(WFMT_Q8, 127, 8'h7F, 32'h7F7F_FFFF, 16'h0001, 1, 0, 0, 1, 0, 0);
    dir_tab[11] = row(WFMT_Q8, -1, 8'h01, 32'h3F80_0000, 16'h7C00, 1, 0, 0, 1, 1, 32'hFF80_0000);
    dir_tab[12] = row(WFMT_Q8, 1, 8'h01, 32'h3F80_0000, 16'h7E01, 1, 0, 0, 1, 1, F32_QNAN);
    // no start: keep adding into the previous accumulator
    dir_tab[13] = row(WFMT_Q8, 2, 8'h02, 32'h3F80_0000, 16'h3C00, 0, 0, 0, 1, 0, 0);
    dir_tab[14] = row(WFMT_Q8, 127, 8'h7F, 32'h0000_0001, 16'h3C00, 1, 0, 0, 1, 0, 0);
    dir_tab[15] = row(WFMT_Q8, -128, 8'h80, 32'h7F7F_FFFF, 16'hFBFF, 1, 0, 0, 1, 1,
                      32'hFF80_0000);
    dir_tab[16] = row(WFMT_Q4, 1, 8'h00, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'hC100_0000);
    dir_tab[17] = row(WFMT_Q4, 1, 8'h0F, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'h40E0_0000);
    dir_tab[18] = row(WFMT_Q4, -128, 8'hF0, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1,
                      32'h4480_0000);
    dir_tab[19] = row(WFMT_Q4, 127, 8'h88, 32'h3F80_0000, 16'h3C00, 1, 0, 0, 1, 1, 32'h0);
    dir_tab[20] = row(WFMT_Q8, 1, 8'hFF, 32'h3F80_0000, 16'h3C00, 1, 1, 32'h3F80_0000, 1, 1,
                      32'h0);

    // hold reset
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < 21; i++) begin
      if (dir_tab[i].fmt != fmt_cur) set_format(dir_tab[i].fmt);
      send_elem(dir_tab[i].el, dir_tab[i].typed, dir_tab[i].result);
    end

    // random phases, alternating weight format
    for (int ph = 0; ph < 5; ph++) begin
      set_format((ph % 2) ? WFMT_Q4 : WFMT_Q8);
      quiet = (ph == 4);
      sent = 0;
      while (sent < 200) begin
        send_random_dot();
        // hold off the sender until every pending result is out
        if (ph == 2 && sent >= 100 && sent < 140) begin
          in_ch.valid <= 1'b0;
          while (dot_expect_q.size() != 0) @(posedge clk);
          sent = 140;
        end
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
